// File: design/stacd_pkg.sv
// Package for the structured-text ASSERT call detector.
// Holds mode and token codes, character constants and byte classifiers.
// No dependencies.
`default_nettype none

package stacd_pkg;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;

    localparam logic [2:0] TK_NONE     = 3'd0;
    localparam logic [2:0] TK_ASSERT   = 3'd1;
    localparam logic [2:0] TK_FUNCTION = 3'd2;
    localparam logic [2:0] TK_DOT      = 3'd3;
    localparam logic [2:0] TK_LPAREN   = 3'd4;
    localparam logic [2:0] TK_OTHER    = 3'd5;
    localparam logic [2:0] TK_IDENT    = 3'd6;

    localparam logic [2:0] AS_DONE = 3'd6;
    localparam logic [2:0] AS_BAD  = 3'd7;
    localparam logic [3:0] FN_DONE = 4'd8;
    localparam logic [3:0] FN_BAD  = 4'd15;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    function automatic logic f_is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] b);
        return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
    endfunction

    function automatic logic f_is_ident_start(input logic [7:0] b);
        return f_is_alpha(b) || (b == CH_UNDER);
    endfunction

    function automatic logic f_is_ident_cont(input logic [7:0] b);
        return f_is_ident_start(b) || (b >= CH_DIG0 && b <= CH_DIG9);
    endfunction

    function automatic logic [7:0] f_upper(input logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) ? b - CASE_DIFF : b;
    endfunction

    function automatic logic [7:0] f_assert_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = "A";
            3'd1: c = "S";
            3'd2: c = "S";
            3'd3: c = "E";
            3'd4: c = "R";
            3'd5: c = "T";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_function_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = "F";
            3'd1: c = "U";
            3'd2: c = "N";
            3'd3: c = "C";
            3'd4: c = "T";
            3'd5: c = "I";
            3'd6: c = "O";
            3'd7: c = "N";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] f_match_assert(input logic [2:0] m, input logic [7:0] b);
        logic [2:0] r;
        if (m < AS_DONE && f_assert_char(m) == f_upper(b)) begin
            r = m + 3'd1;
        end else begin
            r = AS_BAD;
        end
        return r;
    endfunction

    function automatic logic [3:0] f_match_function(input logic [3:0] m, input logic [7:0] b);
        logic [3:0] r;
        if (m < FN_DONE && f_function_char(m[2:0]) == f_upper(b)) begin
            r = m + 4'd1;
        end else begin
            r = FN_BAD;
        end
        return r;
    endfunction

    function automatic logic [2:0] f_ident_kind(input logic [2:0] ma, input logic [3:0] mf);
        logic [2:0] k;
        if (ma == AS_DONE) begin
            k = TK_ASSERT;
        end else if (mf == FN_DONE) begin
            k = TK_FUNCTION;
        end else begin
            k = TK_IDENT;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// File: design/structured_text_assert_call_detector.sv
// Top level of the structured-text ASSERT call detector: byte lexer and result register.
// Depends on stacd_pkg.
// Accepts one byte per cycle unless stalled; a source's summary beat follows its last byte.
`default_nettype none

// One source byte is taken per clock cycle, back to back, through an input register, unless
// a last byte stalls there; all lexer state for that byte is updated by one pass of short
// logic as it leaves that register, so the sustained rate is one byte per cycle. The summary
// beat is registered when the last byte is processed and sits in an output register, so
// input bytes of the next source keep flowing while it waits; only a second last byte stalls
// until the first summary is taken. Offset, line, column and comment depth saturate at their
// widths. After each last byte the block returns to its reset state for the next source.
module structured_text_assert_call_detector #(
    parameter int OFFSET_WIDTH = 24,
    parameter int LINE_WIDTH   = 20,
    parameter int COLUMN_WIDTH = 16,
    parameter int DEPTH_WIDTH  = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [7:0]              i_source_byte,
    input  wire logic                    i_last_byte,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_library_used,
    output logic                         o_assert_declared,
    output logic [OFFSET_WIDTH-1:0]      o_call_offset,
    output logic [LINE_WIDTH-1:0]        o_call_line,
    output logic [COLUMN_WIDTH-1:0]      o_call_column,
    output logic [COLUMN_WIDTH-1:0]      o_call_end_column
);
    import stacd_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX   = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX  = '1;
    localparam logic [COLUMN_WIDTH-1:0] COL_MAX   = '1;
    localparam logic [DEPTH_WIDTH-1:0]  DEPTH_MAX = '1;
    localparam logic [COLUMN_WIDTH-1:0] COL_ONE   = COLUMN_WIDTH'(1);
    localparam logic [LINE_WIDTH-1:0]   LINE_ONE  = LINE_WIDTH'(1);
    localparam logic [COLUMN_WIDTH-1:0] COL_SIX   = COLUMN_WIDTH'(6);
    localparam logic [DEPTH_WIDTH-1:0]  DEPTH_ONE = DEPTH_WIDTH'(1);

    typedef struct packed {
        logic [2:0]              prev_kind;
        logic                    after_dot;
        logic                    call_found;
        logic                    decl_found;
        logic [OFFSET_WIDTH-1:0] f_offset;
        logic [LINE_WIDTH-1:0]   f_line;
        logic [COLUMN_WIDTH-1:0] f_column;
    } t_tok;

    function automatic t_tok f_emit(
        input t_tok                    s,
        input logic [2:0]              kind,
        input logic [OFFSET_WIDTH-1:0] off,
        input logic [LINE_WIDTH-1:0]   line,
        input logic [COLUMN_WIDTH-1:0] col
    );
        t_tok r;
        r = s;
        if (kind == TK_ASSERT) begin
            if (s.prev_kind == TK_FUNCTION) begin
                r.decl_found = 1'b1;
            end
            r.after_dot = (s.prev_kind == TK_DOT);
        end else if (kind == TK_LPAREN) begin
            if (s.prev_kind == TK_ASSERT && !s.after_dot && !s.call_found) begin
                r.call_found = 1'b1;
                r.f_offset   = off;
                r.f_line     = line;
                r.f_column   = col;
            end
        end
        r.prev_kind = kind;
        return r;
    endfunction

    // input stage
    logic                    r_in_valid;
    logic [7:0]              r_byte;
    logic                    r_last;
    logic                    proc_go;

    // lexer state
    logic [1:0]              r_mode,        n_mode;
    logic [DEPTH_WIDTH-1:0]  r_depth,       n_depth;
    logic                    r_dq,          n_dq;
    logic                    r_esc,         n_esc;
    logic                    r_open,        n_open;
    logic                    r_close,       n_close;
    logic                    r_id_active,   n_id_active;
    logic [2:0]              r_m_as,        n_m_as;
    logic [3:0]              r_m_fn,        n_m_fn;
    logic [OFFSET_WIDTH-1:0] r_id_offset,   n_id_offset;
    logic [LINE_WIDTH-1:0]   r_id_line,     n_id_line;
    logic [COLUMN_WIDTH-1:0] r_id_column,   n_id_column;
    t_tok                    r_tk,          n_tk;
    logic [OFFSET_WIDTH-1:0] r_offset,      n_offset;
    logic [LINE_WIDTH-1:0]   r_line,        n_line;
    logic [COLUMN_WIDTH-1:0] r_column,      n_column;

    // result stage
    logic                    r_out_valid;
    logic                    r_used;
    logic                    r_decl;
    logic [OFFSET_WIDTH-1:0] r_res_offset;
    logic [LINE_WIDTH-1:0]   r_res_line;
    logic [COLUMN_WIDTH-1:0] r_res_column;
    logic [COLUMN_WIDTH-1:0] r_res_end;

    logic                    n_used;
    logic [COLUMN_WIDTH-1:0] n_end;
    logic                    skip;
    logic [DEPTH_WIDTH-1:0]  depth_dec;

    assign proc_go    = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_go;

    always_comb begin
        n_mode      = r_mode;
        n_depth     = r_depth;
        n_dq        = r_dq;
        n_esc       = r_esc;
        n_open      = r_open;
        n_close     = r_close;
        n_id_active = r_id_active;
        n_m_as      = r_m_as;
        n_m_fn      = r_m_fn;
        n_id_offset = r_id_offset;
        n_id_line   = r_id_line;
        n_id_column = r_id_column;
        n_tk        = r_tk;
        skip        = 1'b0;
        depth_dec   = (r_depth != '0) ? r_depth - DEPTH_ONE : r_depth;

        case (r_mode)
            MODE_COMMENT: begin
                if (r_open) begin
                    n_open = 1'b0;
                    if (r_byte == CH_STAR) begin
                        n_depth = (r_depth == DEPTH_MAX) ? r_depth : r_depth + DEPTH_ONE;
                        skip    = 1'b1;
                    end
                end else if (r_close) begin
                    n_close = 1'b0;
                    if (r_byte == CH_RPAREN) begin
                        n_depth = depth_dec;
                        if (depth_dec == '0) begin
                            n_mode = MODE_NORMAL;
                        end
                        skip = 1'b1;
                    end
                end
                if (!skip) begin
                    if (r_byte == CH_LPAREN) begin
                        n_open = 1'b1;
                    end else if (r_byte == CH_STAR) begin
                        n_close = 1'b1;
                    end
                end
            end
            MODE_STRING: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (r_byte == CH_DOLLAR) begin
                    n_esc = 1'b1;
                end else if (r_byte == (r_dq ? CH_DQUOTE : CH_SQUOTE)) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                if (r_open) begin
                    n_open = 1'b0;
                    if (r_byte == CH_STAR) begin
                        n_mode  = MODE_COMMENT;
                        n_depth = DEPTH_ONE;
                        n_close = 1'b0;
                        skip    = 1'b1;
                    end else begin
                        n_tk = f_emit(n_tk, TK_LPAREN, r_id_offset, r_id_line, r_id_column);
                    end
                end
                if (!skip && r_id_active) begin
                    if (f_is_ident_cont(r_byte)) begin
                        n_m_as = f_match_assert(r_m_as, r_byte);
                        n_m_fn = f_match_function(r_m_fn, r_byte);
                        skip   = 1'b1;
                    end else begin
                        n_tk = f_emit(n_tk, f_ident_kind(r_m_as, r_m_fn),
                                      r_id_offset, r_id_line, r_id_column);
                        n_id_active = 1'b0;
                    end
                end
                if (!skip && !f_is_space(r_byte)) begin
                    if (r_byte == CH_LPAREN) begin
                        if (r_last) begin
                            n_tk = f_emit(n_tk, TK_LPAREN, r_id_offset, r_id_line, r_id_column);
                        end else begin
                            n_open = 1'b1;
                        end
                    end else if (r_byte == CH_SQUOTE || r_byte == CH_DQUOTE) begin
                        n_mode = MODE_STRING;
                        n_dq   = (r_byte == CH_DQUOTE);
                        n_esc  = 1'b0;
                    end else if (f_is_ident_start(r_byte)) begin
                        n_id_active = 1'b1;
                        n_id_offset = r_offset;
                        n_id_line   = r_line;
                        n_id_column = r_column;
                        n_m_as      = f_match_assert(3'd0, r_byte);
                        n_m_fn      = f_match_function(4'd0, r_byte);
                    end else begin
                        n_tk = f_emit(n_tk, (r_byte == CH_DOT) ? TK_DOT : TK_OTHER,
                                      r_id_offset, r_id_line, r_id_column);
                    end
                end
            end
        endcase

        // close an identifier that runs up to the last byte
        if (r_last && n_mode == MODE_NORMAL && n_id_active) begin
            n_tk = f_emit(n_tk, f_ident_kind(n_m_as, n_m_fn),
                          r_id_offset, r_id_line, r_id_column);
        end

        n_used = n_tk.call_found && !n_tk.decl_found;
        n_end  = (n_tk.f_column > COL_MAX - COL_SIX) ? COL_MAX : n_tk.f_column + COL_SIX;

        n_offset = (r_offset == OFF_MAX) ? r_offset : r_offset + OFFSET_WIDTH'(1);
        if (r_byte == CH_NL) begin
            n_line   = (r_line == LINE_MAX) ? r_line : r_line + LINE_ONE;
            n_column = COL_ONE;
        end else begin
            n_line   = r_line;
            n_column = (r_column == COL_MAX) ? r_column : r_column + COL_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_source_byte;
            r_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc_go && r_last)) begin
            r_mode      <= MODE_NORMAL;
            r_depth     <= '0;
            r_dq        <= 1'b0;
            r_esc       <= 1'b0;
            r_open      <= 1'b0;
            r_close     <= 1'b0;
            r_id_active <= 1'b0;
            r_m_as      <= 3'd0;
            r_m_fn      <= 4'd0;
            r_id_offset <= '0;
            r_id_line   <= LINE_ONE;
            r_id_column <= COL_ONE;
            r_tk        <= '0;
            r_offset    <= '0;
            r_line      <= LINE_ONE;
            r_column    <= COL_ONE;
        end else if (proc_go) begin
            r_mode      <= n_mode;
            r_depth     <= n_depth;
            r_dq        <= n_dq;
            r_esc       <= n_esc;
            r_open      <= n_open;
            r_close     <= n_close;
            r_id_active <= n_id_active;
            r_m_as      <= n_m_as;
            r_m_fn      <= n_m_fn;
            r_id_offset <= n_id_offset;
            r_id_line   <= n_id_line;
            r_id_column <= n_id_column;
            r_tk        <= n_tk;
            r_offset    <= n_offset;
            r_line      <= n_line;
            r_column    <= n_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && r_last) begin
            r_used       <= n_used;
            r_decl       <= n_tk.decl_found;
            r_res_offset <= n_used ? n_tk.f_offset : '0;
            r_res_line   <= n_used ? n_tk.f_line : '0;
            r_res_column <= n_used ? n_tk.f_column : '0;
            r_res_end    <= n_used ? n_end : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_library_used    = r_used;
    assign o_assert_declared = r_decl;
    assign o_call_offset     = r_res_offset;
    assign o_call_line       = r_res_line;
    assign o_call_column     = r_res_column;
    assign o_call_end_column = r_res_end;

endmodule

`default_nettype wire
